// ===== design/glms_pkg.sv =====
// ----------------------------------------------------------------------------
// glms_pkg
// Shared widths, register indexes, types and compare helpers for the
// grid local minimum sum block.
// ----------------------------------------------------------------------------
package glms_pkg;

   localparam int HEIGHT_W        = 4;
   localparam int SUM_W           = 20;
   localparam int DIM_W           = 9;
   localparam int CSR_IDX_W       = 2;
   localparam int DEF_MAX_COLUMNS = 256;
   localparam int DEF_MAX_ROWS    = 256;

   localparam logic [SUM_W-1:0]     SUM_MAX   = '1;
   localparam logic [DIM_W-1:0]     DIM_RESET = 9'd256;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS    = 2'd1;

   typedef struct packed {
      logic wr_en;
      logic clear;
   } ls_ctrl_type;

   typedef struct packed {
      logic [HEIGHT_W-1:0] up;
      logic [HEIGHT_W-1:0] up_right;
      logic [HEIGHT_W-1:0] up2;
   } nbr_type;

   function automatic logic is_low(
      input logic [HEIGHT_W-1:0] v,
      input logic                has_l,
      input logic [HEIGHT_W-1:0] l,
      input logic                has_r,
      input logic [HEIGHT_W-1:0] r,
      input logic                has_u,
      input logic [HEIGHT_W-1:0] u,
      input logic                has_d,
      input logic [HEIGHT_W-1:0] d
   );
      return (!has_l || (v < l)) && (!has_r || (v < r)) &&
             (!has_u || (v < u)) && (!has_d || (v < d));
   endfunction

   function automatic logic [HEIGHT_W:0] risk_of(
      input logic                low,
      input logic [HEIGHT_W-1:0] v
   );
      return low ? ({1'b0, v} + (HEIGHT_W+1)'(1)) : '0;
   endfunction

endpackage

// ===== design/glms_ram.sv =====
// ----------------------------------------------------------------------------
// glms_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module glms_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/glms_line_store.sv =====
// ----------------------------------------------------------------------------
// glms_line_store
// Two line stores (previous row and the row before it) with prefetched
// reads, write bypass and a fill count that makes unwritten entries read 0.
// ----------------------------------------------------------------------------
module glms_line_store #(
   parameter int MAX_COLUMNS = glms_pkg::DEF_MAX_COLUMNS,
   localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  glms_pkg::ls_ctrl_type         ctrl,
   input  logic [CW-1:0]                 wr_col,
   input  logic [glms_pkg::HEIGHT_W-1:0] wr_height,
   input  logic [CW-1:0]                 rd_col,
   output glms_pkg::nbr_type             nbr
);
   import glms_pkg::*;

   localparam int FW = $clog2(MAX_COLUMNS + 1);

   logic [FW-1:0]       fill_ff, fill_in;
   logic [FW-1:0]       wr_end, rd_pos, rd_right;
   logic [FW-1:0]       rd_pos_ff, rd_right_ff;
   logic                hit_ff, hit_right_ff;
   logic [HEIGHT_W-1:0] wr_height_ff, older_wdata_ff;
   logic [HEIGHT_W-1:0] prev_q, prev_right_q, older_q, older_wdata;

   assign wr_end   = FW'(wr_col) + FW'(1);
   assign rd_pos   = FW'(rd_col);
   assign rd_right = FW'(rd_col) + FW'(1);

   always_comb begin
      fill_in = fill_ff;
      if (ctrl.wr_en) begin
         if (ctrl.clear) begin
            fill_in = '0;
         end else if (wr_end > fill_ff) begin
            fill_in = wr_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         hit_ff       <= 1'b0;
         hit_right_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         hit_ff       <= ctrl.wr_en && (FW'(wr_col) == rd_pos);
         hit_right_ff <= ctrl.wr_en && (FW'(wr_col) == rd_right);
      end
   end

   always_ff @(posedge clock) begin
      rd_pos_ff      <= rd_pos;
      rd_right_ff    <= rd_right;
      wr_height_ff   <= wr_height;
      older_wdata_ff <= older_wdata;
   end

   // the previous row entry moves down into the older store
   assign older_wdata = nbr.up;

   always_comb begin
      nbr.up       = (rd_pos_ff < fill_ff) ?
                     (hit_ff ? wr_height_ff : prev_q) : '0;
      nbr.up_right = (rd_right_ff < fill_ff) ?
                     (hit_right_ff ? wr_height_ff : prev_right_q) : '0;
      nbr.up2      = (rd_pos_ff < fill_ff) ?
                     (hit_ff ? older_wdata_ff : older_q) : '0;
   end

   glms_ram #(
      .WIDTH (HEIGHT_W),
      .DEPTH (MAX_COLUMNS)
   ) u_prev_row (
      .clock   (clock),
      .wr_en   (ctrl.wr_en),
      .wr_addr (wr_col),
      .wr_data (wr_height),
      .rd_addr (rd_col),
      .rd_data (prev_q)
   );

   glms_ram #(
      .WIDTH (HEIGHT_W),
      .DEPTH (MAX_COLUMNS)
   ) u_prev_row_right (
      .clock   (clock),
      .wr_en   (ctrl.wr_en),
      .wr_addr (wr_col),
      .wr_data (wr_height),
      .rd_addr (CW'(rd_right)),
      .rd_data (prev_right_q)
   );

   glms_ram #(
      .WIDTH (HEIGHT_W),
      .DEPTH (MAX_COLUMNS)
   ) u_older_row (
      .clock   (clock),
      .wr_en   (ctrl.wr_en),
      .wr_addr (wr_col),
      .wr_data (older_wdata),
      .rd_addr (rd_col),
      .rd_data (older_q)
   );

endmodule

// ===== design/grid_local_minimum_sum.sv =====
// ----------------------------------------------------------------------------
// grid_local_minimum_sum
// Result path: last request -> input register -> result register -> rsp_risk_sum.
// Throughput: one request per cycle unless a held result stalls the frame end;
// line store reads for the next cell are issued from the next column position.
// Reset: synchronous; clears position, sum and fill count, no clearing pass.
// ----------------------------------------------------------------------------
module grid_local_minimum_sum #(
   parameter int MAX_COLUMNS = glms_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = glms_pkg::DEF_MAX_ROWS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [glms_pkg::HEIGHT_W-1:0]  req_height,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [glms_pkg::SUM_W-1:0]     rsp_risk_sum,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [glms_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [glms_pkg::DIM_W-1:0]     csr_data
);
   import glms_pkg::*;

   localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CFW = $clog2(MAX_COLUMNS + 1);
   localparam int RFW = $clog2(MAX_ROWS + 1);
   localparam int CKW = (CFW > DIM_W) ? CFW : DIM_W;
   localparam int RKW = (RFW > DIM_W) ? RFW : DIM_W;
   localparam int TW  = SUM_W + 2;

   logic [DIM_W-1:0]    cols_ff, rows_ff;
   logic [CKW-1:0]      cols_k, ncol, col_pos;
   logic [RKW-1:0]      rows_k, nrow, row_pos;
   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       row_ff, row_in;
   logic                in_valid_ff, in_valid_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic                out_valid_ff, out_valid_in;
   logic [SUM_W-1:0]    risk_ff, risk_in;
   logic [SUM_W-1:0]    sum_ff, sum_in, sum_sat;
   logic [HEIGHT_W-1:0] left1_ff, left1_in, left2_ff, left2_in, upl_ff, upl_in;
   logic                last_col, last_row, frame_end;
   logic                has_up, has_up2, has_left, has_left2;
   logic                low_up, low_left, low_self;
   logic                out_free, process, accept;
   logic [TW-1:0]       total;
   ls_ctrl_type         ls_ctrl;
   nbr_type             nbr;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= DIM_RESET;
         rows_ff <= DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COLUMNS: begin
               cols_ff <= csr_data;
            end
            CSR_ROWS: begin
               rows_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign cols_k = CKW'(cols_ff);
   assign rows_k = RKW'(rows_ff);
   assign ncol   = (cols_k == '0) ? CKW'(1) :
                   (cols_k > CKW'(MAX_COLUMNS)) ? CKW'(MAX_COLUMNS) : cols_k;
   assign nrow   = (rows_k == '0) ? RKW'(1) :
                   (rows_k > RKW'(MAX_ROWS)) ? RKW'(MAX_ROWS) : rows_k;

   // position of the cell in the input register
   assign col_pos   = CKW'(col_ff) + CKW'(1);
   assign row_pos   = RKW'(row_ff) + RKW'(1);
   assign last_col  = col_pos >= ncol;
   assign last_row  = row_pos >= nrow;
   assign frame_end = last_col && last_row;
   assign has_up    = row_ff != '0;
   assign has_up2   = row_ff > RW'(1);
   assign has_left  = col_ff != '0;
   assign has_left2 = col_ff > CW'(1);

   // handshake
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && (!frame_end || out_free);
   assign req_stall = in_valid_ff && !process;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid    = out_valid_ff;
   assign rsp_risk_sum = risk_ff;

   // low point decisions
   assign low_up   = has_up &&
                     is_low(nbr.up, has_left, upl_ff, !last_col, nbr.up_right,
                            has_up2, nbr.up2, 1'b1, height_ff);
   assign low_left = last_row && has_left &&
                     is_low(left1_ff, has_left2, left2_ff, 1'b1, height_ff,
                            has_up, upl_ff, 1'b0, '0);
   assign low_self = frame_end &&
                     is_low(height_ff, has_left, left1_ff, 1'b0, '0,
                            has_up, nbr.up, 1'b0, '0);

   assign total   = {2'b00, sum_ff} + TW'(risk_of(low_up, nbr.up)) +
                    TW'(risk_of(low_left, left1_ff)) + TW'(risk_of(low_self, height_ff));
   assign sum_sat = (total > {2'b00, SUM_MAX}) ? SUM_MAX : total[SUM_W-1:0];

   always_comb begin
      in_valid_in  = accept || (in_valid_ff && !process);
      height_in    = accept ? req_height : height_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      risk_in      = risk_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      sum_in       = sum_ff;
      left1_in     = left1_ff;
      left2_in     = left2_ff;
      upl_in       = upl_ff;
      if (process) begin
         left1_in = frame_end ? '0 : height_ff;
         left2_in = left1_ff;
         upl_in   = nbr.up;
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : (row_ff + RW'(1));
         end else begin
            col_in = col_ff + CW'(1);
         end
         if (frame_end) begin
            out_valid_in = 1'b1;
            risk_in      = sum_sat;
            sum_in       = '0;
         end else begin
            sum_in = sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         sum_ff       <= '0;
         left1_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         sum_ff       <= sum_in;
         left1_ff     <= left1_in;
      end
   end

   always_ff @(posedge clock) begin
      height_ff <= height_in;
      risk_ff   <= risk_in;
      left2_ff  <= left2_in;
      upl_ff    <= upl_in;
   end

   assign ls_ctrl.wr_en = process;
   assign ls_ctrl.clear = frame_end;

   glms_line_store #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_line_store (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ls_ctrl),
      .wr_col    (col_ff),
      .wr_height (height_ff),
      .rd_col    (col_in),
      .nbr       (nbr)
   );

endmodule

// ===== design/glms_checker.sv =====
// ----------------------------------------------------------------------------
// glms_checker
// Port level checks for grid_local_minimum_sum, attached by bind.
// ----------------------------------------------------------------------------
module glms_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [glms_pkg::HEIGHT_W-1:0]  req_height,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [glms_pkg::SUM_W-1:0]     rsp_risk_sum,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [glms_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [glms_pkg::DIM_W-1:0]     csr_data
);

   // empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

   // request side only backs up behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_risk_sum))
      else $error("stalled result changed");

   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(!rsp_stall))
      else $error("result dropped while stalled");

endmodule

bind grid_local_minimum_sum glms_checker u_glms_checker (.*);
